// File: hw/rtl/vmc_pkg.sv
// vmc_pkg: types, constants and helpers for the vending controller
// depends on nothing; used by vmc_if.sv and coin_vending_controller_with_change.sv
`timescale 1ns / 1ps

package vmc_pkg;

  localparam int CREDIT_MAX = 255;

  localparam int CreditW   = 8;
  localparam int PriceW    = 8;
  localparam int CountW    = 8;
  localparam int StockW    = 4;
  localparam int NumCoins  = 5;
  localparam int NumProds  = 3;

  localparam logic [StockW-1:0] StockReset      = 4'd10;
  localparam logic [PriceW-1:0] PricePlainReset = 8'd8;
  localparam logic [PriceW-1:0] PriceMilkReset  = 8'd12;
  localparam logic [PriceW-1:0] PriceChocReset  = 8'd14;

  typedef enum logic [2:0] {
    StCoinOk   = 3'd0,
    StCoinRej  = 3'd1,
    StExact    = 3'd2,
    StChange   = 3'd3,
    StShort    = 3'd4,
    StSoldOut  = 3'd5,
    StBadProd  = 3'd6
  } status_e;

  typedef enum logic {
    KindCoin   = 1'b0,
    KindSelect = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    CfgPricePlain = 2'd0,
    CfgPriceMilk  = 2'd1,
    CfgPriceChoc  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    Coin5   = 4'd1,
    Coin10  = 4'd2,
    Coin25  = 4'd3,
    Coin50  = 4'd4,
    Coin100 = 4'd5
  } coin_e;

  typedef enum logic [1:0] {
    ProdNone  = 2'd0,
    ProdPlain = 2'd1,
    ProdMilk  = 2'd2,
    ProdChoc  = 2'd3
  } prod_e;

  // coin value in 5-cent units, zero for an unknown code
  function automatic logic [4:0] coin_units(input logic [3:0] code);
    logic [4:0] val;
    case (code)
      Coin5:   val = 5'd1;
      Coin10:  val = 5'd2;
      Coin25:  val = 5'd5;
      Coin50:  val = 5'd10;
      Coin100: val = 5'd20;
      default: val = 5'd0;
    endcase
    return val;
  endfunction

endpackage

// File: hw/rtl/vmc_if.sv
// vmc_in_if and vmc_out_if: valid/ready channels of the vending controller
// depends on vmc_pkg
`timescale 1ns / 1ps

interface vmc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] coin_code;
  logic [1:0] product;

  modport source (output valid, kind, coin_code, product, input ready);
  modport sink   (input valid, kind, coin_code, product, output ready);
endinterface

interface vmc_out_if;
  logic                              valid;
  logic                              ready;
  vmc_pkg::status_e                  status;
  logic [vmc_pkg::CreditW-1:0]       credit;
  logic [1:0]                        served_product;
  logic [vmc_pkg::CountW-1:0]        out_100;
  logic [vmc_pkg::CountW-1:0]        out_50;
  logic [vmc_pkg::CountW-1:0]        out_25;
  logic [vmc_pkg::CountW-1:0]        out_10;
  logic [vmc_pkg::CountW-1:0]        out_5;

  modport source (output valid, status, credit, served_product,
                  output out_100, out_50, out_25, out_10, out_5, input ready);
  modport sink   (input valid, status, credit, served_product,
                  input out_100, out_50, out_25, out_10, out_5, output ready);
endinterface

// File: hw/rtl/coin_vending_controller_with_change.sv
// coin_vending_controller_with_change: coin credit, product sale and change
// depends on vmc_pkg and vmc_if
`timescale 1ns / 1ps

// Vending controller. Each input transfer is a coin or a product selection and
// gives exactly one result transfer. An item is captured in an input register,
// evaluated combinationally against the credit, coin counts and stock, and
// written to the result register while the state updates; a new item can be
// taken every cycle while the result register is empty or taken, so throughput
// is then one item per clock. The result register stalls the input side only
// when it is full and not taken. Prices are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; the user must write prices only while the block is idle, the block
// itself does not enforce this; index 3 is ignored. Change is split greedily into
// 100, 50, 25, 10 and 5 cent coins with a constant-multiply divide by 20.
module coin_vending_controller_with_change (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  vmc_in_if.sink                       in_i,
  vmc_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [vmc_pkg::PriceW-1:0]   cfg_data_i
);

  // input register
  logic       in_vld_q;
  logic       kind_q;
  logic [3:0] code_q;
  logic [1:0] prod_q;

  // block state
  logic [vmc_pkg::CreditW-1:0] credit_q, credit_d;
  logic [vmc_pkg::CountW-1:0]  count_q [vmc_pkg::NumCoins];
  logic [vmc_pkg::CountW-1:0]  count_d [vmc_pkg::NumCoins];
  logic [vmc_pkg::StockW-1:0]  stock_q [vmc_pkg::NumProds];
  logic [vmc_pkg::StockW-1:0]  stock_d [vmc_pkg::NumProds];
  logic [vmc_pkg::PriceW-1:0]  price_q [vmc_pkg::NumProds];

  // result register
  logic                        out_vld_q;
  vmc_pkg::status_e            status_q, status_d;
  logic [vmc_pkg::CreditW-1:0] res_credit_q;
  logic [1:0]                  served_q, served_d;
  logic [vmc_pkg::CountW-1:0]  ret_q [vmc_pkg::NumCoins];
  logic [vmc_pkg::CountW-1:0]  ret_d [vmc_pkg::NumCoins];

  logic advance;

  // combinational terms
  logic [4:0]                  coin_val;
  logic [8:0]                  sum;
  logic                        coin_over;
  logic [vmc_pkg::PriceW-1:0]  price_sel;
  logic [vmc_pkg::StockW-1:0]  stock_sel;
  logic [vmc_pkg::CreditW-1:0] rem;
  logic [9:0]                  mul13;
  logic [3:0]                  q100;
  logic [7:0]                  sub100;
  logic [4:0]                  r20;
  logic                        q50;
  logic [3:0]                  r10;
  logic                        q25;
  logic [2:0]                  r5;

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q <= in_i.kind;
      code_q <= in_i.coin_code;
      prod_q <= in_i.product;
    end
  end

  // price and stock of the selected product
  always_comb begin
    case (prod_q)
      vmc_pkg::ProdPlain: begin
        price_sel = price_q[0];
        stock_sel = stock_q[0];
      end
      vmc_pkg::ProdMilk: begin
        price_sel = price_q[1];
        stock_sel = stock_q[1];
      end
      vmc_pkg::ProdChoc: begin
        price_sel = price_q[2];
        stock_sel = stock_q[2];
      end
      default: begin
        price_sel = '0;
        stock_sel = '0;
      end
    endcase
  end

  assign coin_val  = vmc_pkg::coin_units(code_q);
  assign sum       = {1'b0, credit_q} + {4'b0, coin_val};
  assign coin_over = (int'(sum) > vmc_pkg::CREDIT_MAX) || sum[8];

  // greedy change split, rem / 20 as (rem >> 2) * 13 >> 6
  assign rem    = credit_q - price_sel;
  assign mul13  = {4'b0, rem[7:2]} * 10'd13;
  assign q100   = mul13[9:6];
  assign sub100 = {4'b0, q100} * 8'd20;
  assign r20    = 5'(rem - sub100);
  assign q50    = (r20 >= 5'd10);
  assign r10    = q50 ? 4'(r20 - 5'd10) : r20[3:0];
  assign q25    = (r10 >= 4'd5);
  assign r5     = q25 ? 3'(r10 - 4'd5) : r10[2:0];

  always_comb begin
    status_d = vmc_pkg::StCoinRej;
    credit_d = credit_q;
    served_d = vmc_pkg::ProdNone;
    for (int i = 0; i < vmc_pkg::NumCoins; i++) begin
      count_d[i] = count_q[i];
      ret_d[i]   = '0;
    end
    for (int i = 0; i < vmc_pkg::NumProds; i++) begin
      stock_d[i] = stock_q[i];
    end

    if (kind_q == vmc_pkg::KindCoin) begin
      if (coin_val != 5'd0 && !coin_over) begin
        status_d = vmc_pkg::StCoinOk;
        credit_d = sum[7:0];
        for (int i = 0; i < vmc_pkg::NumCoins; i++) begin
          if (code_q == 4'(i + 1) && count_q[i] != '1) begin
            count_d[i] = count_q[i] + 1'b1;
          end
        end
      end
    end else if (prod_q == vmc_pkg::ProdNone || stock_sel == '0) begin
      // refund of the coins inserted in this session
      status_d = (prod_q == vmc_pkg::ProdNone) ? vmc_pkg::StBadProd : vmc_pkg::StSoldOut;
      credit_d = '0;
      for (int i = 0; i < vmc_pkg::NumCoins; i++) begin
        ret_d[i]   = count_q[vmc_pkg::NumCoins - 1 - i];
        count_d[i] = '0;
      end
    end else if (credit_q < price_sel) begin
      status_d = vmc_pkg::StShort;
    end else begin
      status_d = (rem == '0) ? vmc_pkg::StExact : vmc_pkg::StChange;
      served_d = prod_q;
      credit_d = '0;
      ret_d[0] = {4'b0, q100};
      ret_d[1] = {7'b0, q50};
      ret_d[2] = {7'b0, q25};
      ret_d[3] = {6'b0, r5[2:1]};
      ret_d[4] = {7'b0, r5[0]};
      for (int i = 0; i < vmc_pkg::NumCoins; i++) begin
        count_d[i] = '0;
      end
      for (int i = 0; i < vmc_pkg::NumProds; i++) begin
        if (prod_q == 2'(i + 1)) begin
          stock_d[i] = stock_q[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      for (int i = 0; i < vmc_pkg::NumCoins; i++) begin
        count_q[i] <= '0;
      end
      for (int i = 0; i < vmc_pkg::NumProds; i++) begin
        stock_q[i] <= vmc_pkg::StockReset;
      end
    end else if (advance) begin
      credit_q <= credit_d;
      count_q  <= count_d;
      stock_q  <= stock_d;
    end
  end

  // price registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      price_q[0] <= vmc_pkg::PricePlainReset;
      price_q[1] <= vmc_pkg::PriceMilkReset;
      price_q[2] <= vmc_pkg::PriceChocReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vmc_pkg::CfgPricePlain: price_q[0] <= cfg_data_i;
        vmc_pkg::CfgPriceMilk:  price_q[1] <= cfg_data_i;
        vmc_pkg::CfgPriceChoc:  price_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q     <= status_d;
      res_credit_q <= credit_d;
      served_q     <= served_d;
      ret_q        <= ret_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.status         = status_q;
  assign out_o.credit         = res_credit_q;
  assign out_o.served_product = served_q;
  assign out_o.out_100        = ret_q[0];
  assign out_o.out_50         = ret_q[1];
  assign out_o.out_25         = ret_q[2];
  assign out_o.out_10         = ret_q[3];
  assign out_o.out_5          = ret_q[4];

`ifndef SYNTHESIS
  a_credit_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(credit_q) <= vmc_pkg::CREDIT_MAX)
    else $error("credit above maximum");

  a_served_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && served_q != vmc_pkg::ProdNone |->
      status_q == vmc_pkg::StExact || status_q == vmc_pkg::StChange)
    else $error("product served without a sale status");

  a_session_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (status_q == vmc_pkg::StExact || status_q == vmc_pkg::StChange ||
                  status_q == vmc_pkg::StSoldOut || status_q == vmc_pkg::StBadProd) |->
      res_credit_q == '0)
    else $error("credit not cleared after sale or refund");

  a_stock_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stock_q[0] <= vmc_pkg::StockReset && stock_q[1] <= vmc_pkg::StockReset &&
    stock_q[2] <= vmc_pkg::StockReset)
    else $error("stock above initial fill");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(credit_q) && $stable(stock_q[0]) && $stable(stock_q[1]) &&
      $stable(stock_q[2]))
    else $error("state changed without an item");
`endif

endmodule
